/* sv/tcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants of the ClientHello server-name extractor.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int MAX_NAME_DEFAULT      = 255;
    localparam int MSG_TYPE_CLIENT_HELLO = 1;
    localparam int TAG_SNI               = 0;
    localparam int RANDOM_LEN            = 32;

    // result queue between the parser and the output port
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_HELLO = 3'd1,
        ST_NO_NAME   = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_MALFORMED = 3'd4
    } tcs_status_t;

    typedef enum logic {
        KIND_NAME   = 1'b0,
        KIND_STATUS = 1'b1
    } tcs_kind_t;

    typedef struct packed {
        tcs_kind_t   kind;
        logic [7:0]  name_byte;
        tcs_status_t status;
        logic        end_of_run;
    } tcs_result_t;

    // up to two results per parsed byte, always packed from res0
    typedef struct packed {
        logic [1:0]  count;
        tcs_result_t res0;
        tcs_result_t res1;
    } tcs_push_t;

endpackage

/* sv/tls_client_hello_sni_extract_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extract_top
// Streams a ClientHello byte by byte and reports the server name and status.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one handshake byte per request, s_last on the final byte.
//   m_ channel: one request per host name byte (m_kind 0), then one status
//   request (m_kind 1, m_end_of_run 1) after the byte flagged last.
//   Path: an accepted byte is held in the input register, then goes through
//   the parser into the result queue, which drives the m_ channel.
//   Throughput: one byte per cycle; the parser takes a byte while the result
//   queue has room for two entries, so a stalled receiver backs up into the
//   input register and then s_ready drops. Nothing is lost while stalled.
//   The final byte of a message may give two results (name byte and status);
//   these drain one per cycle while m_ready is high.
//   Reset (aresetn low, synchronous) empties the queue and input register and
//   returns the parser to expecting the handshake type byte.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extract_top #(
    parameter int MAX_NAME = tcs_pkg::MAX_NAME_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_name_byte,
    output logic [2:0] m_status,
    output logic       m_end_of_run
);
    import tcs_pkg::*;

    logic              hold_valid;
    logic [7:0]        hold_byte;
    logic              hold_last;
    logic              take;
    logic              room;
    logic [QUEUE_AW:0] level;
    tcs_push_t         push;
    tcs_result_t       head;

    assign take = hold_valid && room;

    tcs_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last      (s_last),
        .take        (take),
        .hold_valid  (hold_valid),
        .hold_byte   (hold_byte),
        .hold_last   (hold_last)
    );

    tcs_parser #(
        .MAX_NAME (MAX_NAME)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .data_byte (hold_byte),
        .last      (hold_last),
        .push      (push)
    );

    tcs_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_valid && m_ready),
        .head_valid (m_valid),
        .head       (head),
        .room       (room),
        .level      (level)
    );

    assign m_kind       = head.kind;
    assign m_name_byte  = head.name_byte;
    assign m_status     = head.status;
    assign m_end_of_run = head.end_of_run;

`ifndef SYNTHESIS
    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (level <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2)))
        else $error("result push without queue room");
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("result queue overflow");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !hold_valid))
        else $error("results visible after reset");
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_end_of_run == m_kind))
        else $error("end_of_run not on status result");
`endif
endmodule

/* sv/tcs_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_in_stage
// Input register: holds one request until the parser takes it.
// ----------------------------------------------------------------------------
module tcs_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte,
    output logic       hold_last
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
            last_reg <= s_last;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;
    assign hold_last  = last_reg;
endmodule

/* sv/tcs_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_parser
// ClientHello walker: one byte per cycle while take is high, emits name bytes and final status.
// ----------------------------------------------------------------------------
module tcs_parser #(
    parameter int MAX_NAME = tcs_pkg::MAX_NAME_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output tcs_pkg::tcs_push_t push
);
    import tcs_pkg::*;

    localparam int NCW = $clog2(MAX_NAME + 1);

    typedef enum logic [19:0] {
        PH_TYPE      = 20'h00001,
        PH_HSLEN     = 20'h00002,
        PH_VERSION   = 20'h00004,
        PH_RANDOM    = 20'h00008,
        PH_SID_LEN   = 20'h00010,
        PH_SID       = 20'h00020,
        PH_CS_LEN    = 20'h00040,
        PH_CS        = 20'h00080,
        PH_CM_LEN    = 20'h00100,
        PH_CM        = 20'h00200,
        PH_EXTS_LEN  = 20'h00400,
        PH_EXT_TAG   = 20'h00800,
        PH_EXT_LEN   = 20'h01000,
        PH_EXT_SKIP  = 20'h02000,
        PH_SNI_LIST  = 20'h04000,
        PH_SNI_TYPE  = 20'h08000,
        PH_SNI_NLEN  = 20'h10000,
        PH_SNI_NAME  = 20'h20000,
        PH_DONE      = 20'h40000,
        PH_NOT_HELLO = 20'h80000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [5:0]        fcount_reg, fcount_next;
    logic [15:0]       flen_reg, flen_next;
    logic [15:0]       ext_rem_reg, ext_rem_next;
    logic [15:0]       ext_tag_reg, ext_tag_next;
    logic [15:0]       ext_len_reg, ext_len_next;
    logic [NCW-1:0]    ncount_reg, ncount_next;
    logic              found_reg, found_next;
    logic              err_reg, err_next;
    tcs_status_t       status;
    tcs_result_t       name_res;
    tcs_result_t       stat_res;
    logic              name_emit;

    always_comb begin
        phase_next   = phase_reg;
        fcount_next  = fcount_reg;
        flen_next    = flen_reg;
        ext_rem_next = ext_rem_reg;
        ext_tag_next = ext_tag_reg;
        ext_len_next = ext_len_reg;
        ncount_next  = ncount_reg;
        found_next   = found_reg;
        err_next     = err_reg;
        name_emit    = 1'b0;
        status       = ST_FOUND;

        unique case (phase_reg) inside
            PH_TYPE: begin
                phase_next  = (data_byte == 8'(MSG_TYPE_CLIENT_HELLO)) ?
                              PH_HSLEN : PH_NOT_HELLO;
                fcount_next = '0;
                flen_next   = '0;
            end
            PH_HSLEN: begin
                fcount_next = fcount_reg + 6'd1;
                if (fcount_next == 6'd3) begin
                    phase_next  = PH_VERSION;
                    fcount_next = '0;
                    flen_next   = '0;
                end
            end
            PH_VERSION: begin
                fcount_next = fcount_reg + 6'd1;
                if (fcount_next == 6'd2) begin
                    phase_next  = PH_RANDOM;
                    fcount_next = '0;
                    flen_next   = '0;
                end
            end
            PH_RANDOM: begin
                fcount_next = fcount_reg + 6'd1;
                if (fcount_next == 6'(RANDOM_LEN)) begin
                    phase_next  = PH_SID_LEN;
                    fcount_next = '0;
                    flen_next   = '0;
                end
            end
            PH_SID_LEN: begin
                phase_next  = (data_byte == 8'd0) ? PH_CS_LEN : PH_SID;
                fcount_next = '0;
                flen_next   = {8'd0, data_byte};
            end
            PH_SID: begin
                flen_next = flen_reg - 16'd1;
                if (flen_next == 16'd0) begin
                    phase_next  = PH_CS_LEN;
                    fcount_next = '0;
                end
            end
            PH_CS_LEN: begin
                flen_next   = {flen_reg[7:0], data_byte};
                fcount_next = fcount_reg + 6'd1;
                if (fcount_next == 6'd2) begin
                    fcount_next = '0;
                    phase_next  = (flen_next == 16'd0) ? PH_CM_LEN : PH_CS;
                end
            end
            PH_CS: begin
                flen_next = flen_reg - 16'd1;
                if (flen_next == 16'd0) begin
                    phase_next  = PH_CM_LEN;
                    fcount_next = '0;
                end
            end
            PH_CM_LEN: begin
                phase_next   = (data_byte == 8'd0) ? PH_EXTS_LEN : PH_CM;
                fcount_next  = '0;
                flen_next    = {8'd0, data_byte};
                ext_rem_next = '0;
            end
            PH_CM: begin
                flen_next = flen_reg - 16'd1;
                if (flen_next == 16'd0) begin
                    phase_next   = PH_EXTS_LEN;
                    fcount_next  = '0;
                    ext_rem_next = '0;
                end
            end
            PH_EXTS_LEN: begin
                ext_rem_next = {ext_rem_reg[7:0], data_byte};
                fcount_next  = fcount_reg + 6'd1;
                if (fcount_next == 6'd2) begin
                    ext_tag_next = '0;
                    phase_next   = (ext_rem_next == 16'd0) ? PH_DONE : PH_EXT_TAG;
                    fcount_next  = '0;
                    flen_next    = '0;
                end
            end
            PH_EXT_TAG: begin
                ext_tag_next = {ext_tag_reg[7:0], data_byte};
                if (ext_rem_reg != 16'd0) ext_rem_next = ext_rem_reg - 16'd1;
                fcount_next = fcount_reg + 6'd1;
                if (ext_rem_next == 16'd0) begin
                    // header cut off by the end of the list
                    err_next    = 1'b1;
                    phase_next  = PH_DONE;
                    fcount_next = '0;
                    flen_next   = '0;
                end else if (fcount_next == 6'd2) begin
                    phase_next   = PH_EXT_LEN;
                    fcount_next  = '0;
                    flen_next    = '0;
                    ext_len_next = '0;
                end
            end
            PH_EXT_LEN: begin
                ext_len_next = {ext_len_reg[7:0], data_byte};
                if (ext_rem_reg != 16'd0) ext_rem_next = ext_rem_reg - 16'd1;
                fcount_next = fcount_reg + 6'd1;
                if (fcount_next == 6'd2) begin
                    if (ext_len_next > ext_rem_next) err_next = 1'b1;
                    fcount_next = '0;
                    flen_next   = '0;
                    if (ext_len_next == 16'd0) begin
                        if (ext_tag_reg == 16'(TAG_SNI)) err_next = 1'b1;
                        phase_next   = (ext_rem_next == 16'd0) ? PH_DONE : PH_EXT_TAG;
                        ext_tag_next = '0;
                    end else begin
                        phase_next = (ext_tag_reg == 16'(TAG_SNI)) ?
                                     PH_SNI_LIST : PH_EXT_SKIP;
                    end
                end else if (ext_rem_next == 16'd0) begin
                    err_next    = 1'b1;
                    phase_next  = PH_DONE;
                    fcount_next = '0;
                    flen_next   = '0;
                end
            end
            PH_EXT_SKIP, PH_SNI_LIST, PH_SNI_TYPE, PH_SNI_NLEN, PH_SNI_NAME: begin
                if (ext_rem_reg != 16'd0) ext_rem_next = ext_rem_reg - 16'd1;
                ext_len_next = ext_len_reg - 16'd1;
                case (phase_reg)
                    PH_SNI_LIST: begin
                        flen_next   = {flen_reg[7:0], data_byte};
                        fcount_next = fcount_reg + 6'd1;
                        if (fcount_next == 6'd2) begin
                            ext_tag_next = flen_next;
                            phase_next   = PH_SNI_TYPE;
                            fcount_next  = '0;
                            flen_next    = '0;
                        end
                    end
                    PH_SNI_TYPE: begin
                        if (data_byte != 8'd0) err_next = 1'b1;
                        phase_next  = PH_SNI_NLEN;
                        fcount_next = '0;
                        flen_next   = '0;
                    end
                    PH_SNI_NLEN: begin
                        flen_next   = {flen_reg[7:0], data_byte};
                        fcount_next = fcount_reg + 6'd1;
                        if (fcount_next == 6'd2) begin
                            // name length plus type and length bytes must fill the list
                            if (({1'b0, flen_next} + 17'd3) != {1'b0, ext_tag_reg}) begin
                                err_next = 1'b1;
                            end
                            ncount_next = '0;
                            fcount_next = '0;
                            phase_next  = (flen_next == 16'd0) ? PH_EXT_SKIP : PH_SNI_NAME;
                        end
                    end
                    PH_SNI_NAME: begin
                        if (ncount_reg < NCW'(MAX_NAME)) begin
                            name_emit   = 1'b1;
                            found_next  = 1'b1;
                            ncount_next = ncount_reg + NCW'(1);
                        end else begin
                            err_next = 1'b1;
                        end
                        flen_next = flen_reg - 16'd1;
                        if (flen_next == 16'd0) begin
                            phase_next  = PH_EXT_SKIP;
                            fcount_next = '0;
                        end
                    end
                    default: ;
                endcase
                if (ext_len_next == 16'd0) begin
                    if (phase_next != PH_EXT_SKIP) err_next = 1'b1;
                    phase_next   = (ext_rem_next == 16'd0) ? PH_DONE : PH_EXT_TAG;
                    fcount_next  = '0;
                    flen_next    = '0;
                    ext_tag_next = '0;
                end
            end
            default: ;
        endcase

        if (phase_next == PH_NOT_HELLO) status = ST_NOT_HELLO;
        else if (err_next) status = ST_MALFORMED;
        else if (phase_next == PH_EXTS_LEN && fcount_next == 6'd0) status = ST_NO_NAME;
        else if (phase_next != PH_DONE) status = ST_TRUNCATED;
        else status = found_next ? ST_FOUND : ST_NO_NAME;

        if (last) begin
            phase_next   = PH_TYPE;
            fcount_next  = '0;
            flen_next    = '0;
            ext_rem_next = '0;
            ext_tag_next = '0;
            ext_len_next = '0;
            ncount_next  = '0;
            found_next   = 1'b0;
            err_next     = 1'b0;
        end
    end

    always_comb begin
        name_res.kind       = KIND_NAME;
        name_res.name_byte  = data_byte;
        name_res.status     = ST_FOUND;
        name_res.end_of_run = 1'b0;
        stat_res.kind       = KIND_STATUS;
        stat_res.name_byte  = 8'd0;
        stat_res.status     = status;
        stat_res.end_of_run = 1'b1;

        push.count = take ? ({1'b0, name_emit} + {1'b0, last}) : 2'd0;
        push.res0  = name_emit ? name_res : stat_res;
        push.res1  = stat_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TYPE;
            fcount_reg  <= '0;
            flen_reg    <= '0;
            ext_rem_reg <= '0;
            ext_tag_reg <= '0;
            ext_len_reg <= '0;
            ncount_reg  <= '0;
            found_reg   <= 1'b0;
            err_reg     <= 1'b0;
        end else if (take) begin
            phase_reg   <= phase_next;
            fcount_reg  <= fcount_next;
            flen_reg    <= flen_next;
            ext_rem_reg <= ext_rem_next;
            ext_tag_reg <= ext_tag_next;
            ext_len_reg <= ext_len_next;
            ncount_reg  <= ncount_next;
            found_reg   <= found_next;
            err_reg     <= err_next;
        end
    end
endmodule

/* sv/tcs_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_out_queue
// Small result queue: takes up to two results a cycle, drives the m_ port.
// ----------------------------------------------------------------------------
module tcs_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcs_pkg::tcs_push_t   push,
    input  logic                 pop,
    output logic                 head_valid,
    output tcs_pkg::tcs_result_t head,
    output logic                 room,
    output logic [tcs_pkg::QUEUE_AW:0] level
);
    import tcs_pkg::*;

    tcs_result_t           entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   head_reg, head_next;
    logic [QUEUE_AW-1:0]   tail_reg, tail_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic [QUEUE_AW-1:0]   tail_plus1;

    assign tail_plus1 = tail_reg + QUEUE_AW'(1);
    assign head_next  = pop ? head_reg + QUEUE_AW'(1) : head_reg;
    assign tail_next  = tail_reg + QUEUE_AW'(push.count);
    assign count_next = count_reg + (QUEUE_AW + 1)'(push.count)
                        - (QUEUE_AW + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) entries[tail_reg] <= push.res0;
        if (push.count == 2'd2) entries[tail_plus1] <= push.res1;
    end

    assign head_valid = (count_reg != '0);
    assign head       = entries[head_reg];
    // room for a worst-case byte (name byte plus status)
    assign room       = (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
    assign level      = count_reg;
endmodule
